FILE: rtl/bcs_pkg.sv
// Shared constants and types of the budget cutoff selector.
package bcs_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 32;
  localparam int BUDGET_W   = 42;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = VALUE_BITS + IDX_W;
  localparam int T_W        = VALUE_BITS + 1;
  localparam int B_W        = $clog2(T_W);
  localparam int CMP_W      = ((SUM_W > BUDGET_W) ? SUM_W : BUDGET_W) + 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_OUT,
    ST_SEARCH,
    ST_MARK,
    ST_DONE
  } st_t;

endpackage

FILE: rtl/bcs_if.sv
// Channel interfaces for commands in and results out.
interface bcs_in_if;
  import bcs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [VALUE_BITS-1:0]   value;
  logic                    last;
  logic [IDX_W-1:0]        entry_index;
  modport source (output valid, cmd, value, last, entry_index, input ready);
  modport sink   (input valid, cmd, value, last, entry_index, output ready);
endinterface

interface bcs_out_if;
  import bcs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    result_kind;
  logic [CNT_W-1:0]        drop_count;
  logic                    entry_dropped;
  logic [VALUE_BITS-1:0]   entry_value;
  modport source (output valid, result_kind, drop_count, entry_dropped, entry_value,
                  input ready);
  modport sink   (input valid, result_kind, drop_count, entry_dropped, entry_value,
                  output ready);
endinterface

FILE: rtl/budget_cutoff_selector.sv
// Loads a column, finds the budget cutoff over the smallest values, answers reads.
// Loads are taken back to back while idle; a read answer goes out via ST_RD_OUT.
// A last load starts a search of (VALUE_BITS+1) threshold passes plus one marking
// pass, each walking the n loaded entries through the single store read port:
// 34 passes per column, then the count result.
// Reset (synchronous, rst_n low) clears the counts, the budget and the handshake
// state; the value store holds garbage until loaded and needs no clearing pass.
module budget_cutoff_selector (
  input  logic                      clk,
  input  logic                      rst_n,
  bcs_in_if.sink                    in_ch,
  bcs_out_if.source                 out_ch,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bcs_pkg::BUDGET_W-1:0] cfg_data
);
  import bcs_pkg::*;

  // Store word: dropped flag on top of the value.
  logic [VALUE_BITS:0] mem [DEPTH];
  logic [VALUE_BITS:0] mem_rd_r;

  st_t state_r, state_nxt;

  logic [BUDGET_W-1:0] budget_r;
  logic [CNT_W-1:0]    loaded_r;
  logic [CNT_W-1:0]    dropped_r;
  logic                done_r;
  logic [IDX_W-1:0]    rq_idx_r;
  logic                rq_ok_r;

  logic [CNT_W-1:0]    rd_idx_r;
  logic                v1_r;
  logic [IDX_W-1:0]    a1_r;
  logic [SUM_W-1:0]    acc_r;
  logic [SUM_W-1:0]    best_sum_r;
  logic [SUM_W-1:0]    eq_acc_r;
  logic [T_W-1:0]      t_r;
  logic [B_W-1:0]      b_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                out_valid_r;
  logic                out_kind_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_dropped_r;
  logic [VALUE_BITS-1:0] out_value_r;

  logic                in_acc;
  logic                issue;
  logic                pass_end;
  logic                out_free;
  logic                out_load;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [VALUE_BITS:0] mem_wd;
  logic [IDX_W-1:0]    rd_addr;
  logic [CNT_W-1:0]    base_n;
  logic [T_W-1:0]      trial;
  logic [T_W-1:0]      rd_val;
  logic                fit;
  logic                eq_fit;
  logic                drop;
  logic [CMP_W-1:0]    eq_sum;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign base_n    = done_r ? '0 : loaded_r;
  assign trial     = t_r | (T_W'(1) << b_r);
  assign rd_val    = {1'b0, mem_rd_r[VALUE_BITS-1:0]};
  assign fit       = CMP_W'(acc_r) <= CMP_W'(budget_r);
  assign eq_sum    = CMP_W'(eq_acc_r) + CMP_W'(t_r);
  assign eq_fit    = eq_sum <= CMP_W'(budget_r);
  assign drop      = (rd_val < t_r) || ((rd_val == t_r) && eq_fit);
  assign pass_end  = (rd_idx_r == loaded_r) && !v1_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_READ) begin
            state_nxt = ST_RD_WAIT;
          end else if (in_ch.last) begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_RD_WAIT: state_nxt = ST_RD_OUT;
      ST_RD_OUT:  if (out_free) state_nxt = ST_IDLE;
      ST_SEARCH:  if (pass_end && b_r == '0) state_nxt = ST_MARK;
      ST_MARK:    if (pass_end) state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = a1_r;
    mem_wd      = {drop, mem_rd_r[VALUE_BITS-1:0]};
    rd_addr     = rd_idx_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = in_ch.entry_index;
        mem_wa      = base_n[IDX_W-1:0];
        mem_wd      = {1'b0, in_ch.value};
        mem_we      = in_acc && (in_ch.cmd == CMD_LOAD) && (base_n < CNT_W'(DEPTH));
      end
      ST_RD_WAIT: rd_addr = rq_idx_r;
      ST_RD_OUT: begin
        rd_addr  = rq_idx_r;
        out_load = out_free;
      end
      ST_SEARCH: issue = rd_idx_r < loaded_r;
      ST_MARK: begin
        issue  = rd_idx_r < loaded_r;
        mem_we = v1_r;
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      budget_r    <= '0;
      loaded_r    <= '0;
      dropped_r   <= '0;
      done_r      <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        budget_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      v1_r <= issue;
      if (state_r == ST_IDLE && in_acc && in_ch.cmd == CMD_LOAD) begin
        done_r <= 1'b0;
        if (done_r) begin
          dropped_r <= '0;
        end
        loaded_r <= (base_n < CNT_W'(DEPTH)) ? base_n + 1'b1 : base_n;
      end
      if (state_r == ST_MARK && pass_end) begin
        dropped_r <= cnt_r;
        done_r    <= 1'b1;
      end
    end
  end

  // Sweep datapath.
  always_ff @(posedge clk) begin
    a1_r <= rd_idx_r[IDX_W-1:0];
    if (issue) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    if (state_r == ST_IDLE) begin
      rq_idx_r   <= in_ch.entry_index;
      rq_ok_r    <= CNT_W'(in_ch.entry_index) < loaded_r;
      rd_idx_r   <= '0;
      acc_r      <= '0;
      best_sum_r <= '0;
      t_r        <= '0;
      b_r        <= B_W'(VALUE_BITS);
      cnt_r      <= '0;
    end
    if (state_r == ST_SEARCH) begin
      if (v1_r && rd_val < trial) begin
        acc_r <= acc_r + SUM_W'(mem_rd_r[VALUE_BITS-1:0]);
      end
      if (pass_end) begin
        rd_idx_r <= '0;
        acc_r    <= '0;
        if (fit) begin
          t_r        <= trial;
          best_sum_r <= acc_r;
          eq_acc_r   <= acc_r;
        end else begin
          eq_acc_r   <= best_sum_r;
        end
        b_r <= b_r - 1'b1;
      end
    end
    // Entries equal to the threshold fill what is left, in load order.
    if (state_r == ST_MARK && v1_r) begin
      if (drop) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (drop && rd_val == t_r) begin
        eq_acc_r <= eq_sum[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_RD_OUT) begin
        out_kind_r    <= KIND_READ;
        out_count_r   <= dropped_r;
        out_dropped_r <= rq_ok_r && done_r && mem_rd_r[VALUE_BITS];
        out_value_r   <= rq_ok_r ? mem_rd_r[VALUE_BITS-1:0] : '0;
      end else begin
        out_kind_r    <= KIND_DONE;
        out_count_r   <= cnt_r;
        out_dropped_r <= 1'b0;
        out_value_r   <= '0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_kind_r;
  assign out_ch.drop_count    = out_count_r;
  assign out_ch.entry_dropped = out_dropped_r;
  assign out_ch.entry_value   = out_value_r;

endmodule

FILE: rtl/bcs_checker.sv
// Port-level checks of the budget cutoff selector, bound to the top level.
module bcs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_cmd,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [bcs_pkg::CNT_W-1:0]   out_count,
  input logic                        out_dropped,
  input logic [bcs_pkg::VALUE_BITS-1:0] out_value
);
  import bcs_pkg::*;

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> !out_dropped && out_value == '0)
    else $error("column result carries entry data");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("drop count exceeds store depth");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_LOAD && in_last |=> !in_ready)
    else $error("input taken while the cutoff search runs");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_value))
    else $error("stalled result changed");

endmodule

bind budget_cutoff_selector bcs_checker u_bcs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_cmd      (in_ch.cmd),
  .in_last     (in_ch.last),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.result_kind),
  .out_count   (out_ch.drop_count),
  .out_dropped (out_ch.entry_dropped),
  .out_value   (out_ch.entry_value)
);
